// File: hw/rtl/aolq_pkg.sv
package aolq_pkg;

    localparam int CAPACITY  = 64;
    localparam int COST_BITS = 16;

    localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int FIELD_W = 16;
    localparam int AGE_W   = 16;
    localparam int SUM_W   = FIELD_W + 1;

    // Costs are cut to COST_BITS, and never wider than the 16-bit field.
    localparam logic [FIELD_W-1:0] COST_MASK = (COST_BITS >= FIELD_W) ? {FIELD_W{1'b1}}
                                             : FIELD_W'((64'd1 << COST_BITS) - 64'd1);

    typedef enum logic [1:0] {
        MODE_INSERT  = 2'd0,
        MODE_EXTRACT = 2'd1,
        MODE_LOOKUP  = 2'd2,
        MODE_REPLACE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EMPTY     = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [FIELD_W-1:0] id;
        logic [FIELD_W-1:0] g;
        logic [FIELD_W-1:0] h;
        logic [AGE_W-1:0]   age;
    } entry_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } dp_sts_t;

endpackage

// File: hw/rtl/aolq_ctrl.sv
module aolq_ctrl
    import aolq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.start  = 1'b0;
        cmd.scan   = 1'b0;
        cmd.commit = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                cmd.start = in_valid;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            ST_DRAIN:
            begin
            end
            ST_FINISH:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: hw/rtl/aolq_datapath.sv
module aolq_datapath
    import aolq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_sts_t            sts,
    input  logic [1:0]         in_mode,
    input  logic [FIELD_W-1:0] in_id,
    input  logic [FIELD_W-1:0] in_g,
    input  logic [FIELD_W-1:0] in_h,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [FIELD_W-1:0] out_id,
    output logic [FIELD_W-1:0] out_g,
    output logic [FIELD_W-1:0] out_h,
    output logic               out_found,
    output logic [1:0]         out_status,
    output logic               out_is_empty,
    output logic [6:0]         out_count
);

    entry_t mem [CAPACITY];

    logic [CAPACITY-1:0] valid_reg;
    logic [AGE_W-1:0]    age_reg;
    logic [CNT_W-1:0]    live_reg;

    mode_t              mode_reg;
    logic [FIELD_W-1:0] id_reg;
    logic [FIELD_W-1:0] g_reg;
    logic [FIELD_W-1:0] h_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic              last_addr;

    entry_t            rd_word_reg;
    logic              rd_valid_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              eval_reg;

    logic              hit_reg;
    logic [ADDR_W-1:0] slot_reg;
    entry_t            best_word_reg;
    logic [SUM_W-1:0]  best_f_reg;
    logic [AGE_W-1:0]  best_old_reg;

    logic [SUM_W-1:0] cur_f;
    logic [AGE_W-1:0] cur_old;
    logic             cand;

    logic               res_write;
    logic               res_set_valid;
    logic               res_clr_valid;
    logic               res_bump_age;
    logic               res_inc;
    logic               res_dec;
    logic [FIELD_W-1:0] res_id;
    logic [FIELD_W-1:0] res_g;
    logic [FIELD_W-1:0] res_h;
    logic               res_found;
    status_t            res_status;
    logic [CNT_W-1:0]   live_next;

    logic               out_valid_reg;
    logic [FIELD_W-1:0] out_id_reg;
    logic [FIELD_W-1:0] out_g_reg;
    logic [FIELD_W-1:0] out_h_reg;
    logic               out_found_reg;
    logic [1:0]         out_status_reg;
    logic               out_empty_reg;
    logic [6:0]         out_count_reg;

    assign last_addr     = (addr_reg == ADDR_W'(CAPACITY - 1));
    assign addr_next     = last_addr ? '0 : addr_reg + ADDR_W'(1);
    assign sts.scan_last = last_addr;
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Latch the transaction at accept; costs are masked here once.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg <= mode_t'(in_mode);
            id_reg   <= in_id;
            g_reg    <= in_g & COST_MASK;
            h_reg    <= in_h & COST_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
            eval_reg <= 1'b0;
        end
        else
        begin
            eval_reg <= cmd.scan;
            if (cmd.start)
            begin
                addr_reg <= '0;
            end
            else if (cmd.scan)
            begin
                addr_reg <= addr_next;
            end
        end
    end

    // Single read port: one entry per cycle, data registered.
    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            rd_word_reg  <= mem[addr_reg];
            rd_valid_reg <= valid_reg[addr_reg];
            rd_addr_reg  <= addr_reg;
        end
        if (cmd.commit && res_write)
        begin
            mem[slot_reg] <= '{id: id_reg, g: g_reg, h: h_reg, age: age_reg};
        end
    end

    assign cur_f   = SUM_W'(rd_word_reg.g) + SUM_W'(rd_word_reg.h);
    assign cur_old = age_reg - rd_word_reg.age;

    always_comb
    begin
        cand = 1'b0;
        unique case (mode_reg)
            MODE_INSERT:
            begin
                cand = !rd_valid_reg && !hit_reg;
            end
            MODE_EXTRACT:
            begin
                // Strict compares keep the lower slot on a full tie.
                cand = rd_valid_reg && (!hit_reg || (cur_f < best_f_reg)
                       || ((cur_f == best_f_reg) && (cur_old > best_old_reg)));
            end
            MODE_LOOKUP, MODE_REPLACE:
            begin
                cand = rd_valid_reg && (rd_word_reg.id == id_reg) && !hit_reg;
            end
            default:
            begin
                cand = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            hit_reg <= 1'b0;
        end
        else if (eval_reg && cand)
        begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_reg && cand)
        begin
            slot_reg      <= rd_addr_reg;
            best_word_reg <= rd_word_reg;
            best_f_reg    <= cur_f;
            best_old_reg  <= cur_old;
        end
    end

    always_comb
    begin
        res_write     = 1'b0;
        res_set_valid = 1'b0;
        res_clr_valid = 1'b0;
        res_bump_age  = 1'b0;
        res_inc       = 1'b0;
        res_dec       = 1'b0;
        res_id        = id_reg;
        res_g         = '0;
        res_h         = '0;
        res_found     = 1'b0;
        res_status    = STATUS_OK;
        unique case (mode_reg)
            MODE_INSERT:
            begin
                if (hit_reg && (live_reg < CNT_W'(CAPACITY)))
                begin
                    res_write     = 1'b1;
                    res_set_valid = 1'b1;
                    res_bump_age  = 1'b1;
                    res_inc       = 1'b1;
                end
                else
                begin
                    res_status = STATUS_FULL;
                end
            end
            MODE_EXTRACT:
            begin
                if (hit_reg)
                begin
                    res_id        = best_word_reg.id;
                    res_g         = best_word_reg.g;
                    res_h         = best_word_reg.h;
                    res_clr_valid = 1'b1;
                    res_dec       = (live_reg != '0);
                end
                else
                begin
                    res_status = STATUS_EMPTY;
                end
            end
            MODE_LOOKUP:
            begin
                if (hit_reg)
                begin
                    res_found = 1'b1;
                    res_g     = best_word_reg.g;
                end
                else
                begin
                    res_status = STATUS_NOT_FOUND;
                end
            end
            MODE_REPLACE:
            begin
                if (hit_reg)
                begin
                    res_found    = 1'b1;
                    res_write    = 1'b1;
                    res_bump_age = 1'b1;
                end
                else
                begin
                    res_status = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        live_next = live_reg;
        if (res_inc)
        begin
            live_next = live_reg + CNT_W'(1);
        end
        else if (res_dec)
        begin
            live_next = live_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            age_reg   <= '0;
            live_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            if (res_set_valid)
            begin
                valid_reg[slot_reg] <= 1'b1;
            end
            else if (res_clr_valid)
            begin
                valid_reg[slot_reg] <= 1'b0;
            end
            if (res_bump_age)
            begin
                age_reg <= age_reg + AGE_W'(1);
            end
            live_reg <= live_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_id_reg     <= res_id;
            out_g_reg      <= res_g;
            out_h_reg      <= res_h;
            out_found_reg  <= res_found;
            out_status_reg <= res_status;
            out_empty_reg  <= (live_next == '0);
            out_count_reg  <= 7'(live_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_id       = out_id_reg;
    assign out_g        = out_g_reg;
    assign out_h        = out_h_reg;
    assign out_found    = out_found_reg;
    assign out_status   = out_status_reg;
    assign out_is_empty = out_empty_reg;
    assign out_count    = out_count_reg;

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CNT_W'(CAPACITY))
        else $error("live count exceeds capacity");

    a_live_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(live_reg))
        else $error("live count disagrees with valid bits");

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result written over one not yet taken");

    a_extract_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && res_clr_valid) |-> valid_reg[slot_reg])
        else $error("extract removes an entry that is not held");

    a_scan_idle_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !cmd.scan && !eval_reg)
        else $error("commit while the scan is still running");

endmodule

// File: hw/rtl/astar_open_list_queue.sv
// Open-list store for a best-first path search, holding up to CAPACITY entries of
// node id, g and h. The input tuser selects the operation (insert, extract minimum
// g+h with the oldest entry winning ties, lookup by id, replace by id), and each
// input transaction gives exactly one output transaction. Every operation walks the
// whole entry memory through its single read port, one entry per cycle. After an input is
// accepted, the scan state reads all CAPACITY entries, the drain state compares the last
// registered read, and the finish state writes the result register once the output
// register is free; the block then returns to idle. A new transaction is accepted
// only while no operation is in progress; the result sits in an output register,
// so the next transaction may be accepted while a result still waits to be taken,
// and that next operation then holds its result until the output register is free.
module astar_open_list_queue
    import aolq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // node_id[15:0], cost_g[31:16], heuristic_h[47:32]
    input  logic [1:0]  s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // out_id, out_g, out_h, is_empty[48], entry_count[55:49]
    output logic [2:0]  m_tuser   // found[0], status[2:1]
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    logic [FIELD_W-1:0] out_id;
    logic [FIELD_W-1:0] out_g;
    logic [FIELD_W-1:0] out_h;
    logic               out_found;
    logic [1:0]         out_status;
    logic               out_is_empty;
    logic [6:0]         out_count;

    aolq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    aolq_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_mode      (s_tuser),
        .in_id        (s_tdata[15:0]),
        .in_g         (s_tdata[31:16]),
        .in_h         (s_tdata[47:32]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_id       (out_id),
        .out_g        (out_g),
        .out_h        (out_h),
        .out_found    (out_found),
        .out_status   (out_status),
        .out_is_empty (out_is_empty),
        .out_count    (out_count)
    );

    assign m_tdata = {out_count, out_is_empty, out_h, out_g, out_id};
    assign m_tuser = {out_status, out_found};

endmodule
